// ===== design/kftb_pkg.sv =====
// shared types and constants for the kmp failure table builder
package kftb_pkg;

  localparam int MAX_LEN_DEF     = 256;
  localparam int SYMBOL_BITS_DEF = 8;

  localparam int SYMBOL_W   = 8;
  localparam int VALUE_W    = 9;
  localparam int POSITION_W = 8;

  localparam logic [POSITION_W-1:0] OVF_POSITION = '1;

  // apb register map
  localparam int                CFG_AW          = 3;
  localparam int                CFG_DW          = 32;
  localparam logic [CFG_AW-1:0] ADDR_INDEX_MODE = 3'h0;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                first;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [POSITION_W-1:0]     position;
    logic                      overflow;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;         // latch request, read at the starting border
    logic step;         // fall back one border, read again
    logic finish;       // write tables and result for a searched byte
    logic finish_zero;  // write tables and result for the first byte of a string
    logic ovf;          // load the overflow result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pos_full;
    logic pos_zero;
    logic sym_match;
    logic j_zero;
  } dp_sts_t;

endpackage

// ===== design/kftb_datapath.sv =====
// symbol and border memories, border search registers and result register
module kftb_datapath #(
  parameter int MAX_LEN     = kftb_pkg::MAX_LEN_DEF,
  parameter int SYMBOL_BITS = kftb_pkg::SYMBOL_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kftb_pkg::in_t     in_payload,
  input  logic              index_mode,
  input  kftb_pkg::dp_cmd_t cmd,
  output kftb_pkg::dp_sts_t sts,
  output kftb_pkg::out_t    out_payload
);
  import kftb_pkg::*;

  localparam int BW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int SW = (SYMBOL_BITS < SYMBOL_W) ? SYMBOL_BITS : SYMBOL_W;

  logic [SW-1:0] pat_mem [MAX_LEN];
  logic [BW-1:0] brd_mem [MAX_LEN];

  logic [CW-1:0] count_r;
  logic [BW-1:0] cur_r;
  logic [SW-1:0] sym_r;
  logic [BW-1:0] pos_r;
  logic [BW-1:0] j_r;
  logic [SW-1:0] pat_rd_r;
  logic [BW-1:0] brd_rd_r;
  out_t          out_r;

  logic [SW-1:0] in_sym;
  logic [CW-1:0] in_pos;
  logic [BW-1:0] in_cur;
  logic [BW-1:0] start_j;
  logic [BW-1:0] rd_addr;
  logic [BW-1:0] brd_addr;
  logic          match;
  logic [BW-1:0] j_fin;
  logic          wr_en;
  logic [BW-1:0] wr_addr;
  logic [SW-1:0] wr_sym;
  logic [BW-1:0] wr_j;
  logic [31:0]   val32;

  assign in_sym = in_payload.symbol[SW-1:0];
  assign in_pos = in_payload.first ? '0 : count_r;
  assign in_cur = in_payload.first ? '0 : cur_r;

  // border never reaches the position, clamp kept for safety
  assign start_j = (CW'(in_cur) >= in_pos) ? BW'(in_pos - CW'(1)) : in_cur;

  assign rd_addr  = cmd.step ? brd_rd_r : start_j;
  assign brd_addr = (rd_addr == '0) ? '0 : rd_addr - BW'(1);

  assign match = (sym_r == pat_rd_r);
  assign j_fin = match ? j_r + BW'(1) : j_r;

  assign sts.pos_full  = (in_pos >= CW'(MAX_LEN));
  assign sts.pos_zero  = (in_pos == '0);
  assign sts.sym_match = match;
  assign sts.j_zero    = (j_r == '0);

  assign wr_en   = cmd.finish || cmd.finish_zero;
  assign wr_addr = cmd.finish_zero ? '0 : pos_r;
  assign wr_sym  = cmd.finish_zero ? in_sym : sym_r;
  assign wr_j    = cmd.finish_zero ? '0 : j_fin;

  assign val32 = 32'(wr_j) - 32'(index_mode);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat_mem[wr_addr] <= wr_sym;
      brd_mem[wr_addr] <= wr_j;
    end
    if (cmd.load || cmd.step) begin
      pat_rd_r <= pat_mem[rd_addr];
      brd_rd_r <= brd_mem[brd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sym_r <= in_sym;
      pos_r <= BW'(in_pos);
      j_r   <= start_j;
    end else if (cmd.step) begin
      j_r <= brd_rd_r;
    end
    if (wr_en) begin
      out_r.value    <= VALUE_W'(val32);
      out_r.position <= POSITION_W'(32'(wr_addr));
      out_r.overflow <= 1'b0;
    end else if (cmd.ovf) begin
      out_r.value    <= '0;
      out_r.position <= OVF_POSITION;
      out_r.overflow <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cur_r   <= '0;
    end else if (cmd.finish_zero) begin
      count_r <= CW'(1);
      cur_r   <= '0;
    end else if (cmd.finish) begin
      count_r <= CW'(pos_r) + CW'(1);
      cur_r   <= j_fin;
    end
  end

  assign out_payload = out_r;

  // each fallback strictly shortens the border
  a_step_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> (j_r < $past(j_r)))
    else $error("fallback did not shorten the border");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_LEN))
    else $error("byte count beyond capacity");

endmodule

// ===== design/kftb_ctrl.sv =====
// request sequencing and result valid control for the kmp failure table builder
module kftb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  kftb_pkg::dp_sts_t sts,
  output kftb_pkg::dp_cmd_t cmd
);
  import kftb_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_CMP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;
  logic   accept;
  logic   load_out;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (sts.pos_full) begin
            cmd.ovf = 1'b1;
          end else if (sts.pos_zero) begin
            cmd.finish_zero = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (sts.sym_match || sts.j_zero) begin
          // hold the search result until the output register frees up
          if (out_free) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign load_out      = cmd.finish || cmd.finish_zero || cmd.ovf;
  assign out_valid_nxt = load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step, cmd.finish, cmd.finish_zero, cmd.ovf}))
    else $error("more than one datapath command");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending one");

  a_accept_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (cmd.load || cmd.finish_zero || cmd.ovf))
    else $error("accepted request issued no command");

  a_search_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (state_r == ST_IDLE && out_valid_r))
    else $error("finished search did not present a result");

endmodule

// ===== design/kmp_failure_table_builder.sv =====
// top level of the streaming kmp failure table builder with its apb register
//
//  channel  | ports                                   | payload
//  ---------+-----------------------------------------+------------------------------
//  input    | in_valid, in_stall, in_payload          | symbol[7:0], first
//  result   | out_valid, out_stall, out_payload       | value[8:0] signed, position, overflow
//  config   | psel penable pwrite paddr pwdata prdata | index_mode at byte address 0
//
// the first byte of a string and an overflowing byte finish straight from idle, any other byte
// is loaded, then falls back through the border table until its symbol matches or the border is zero.
// each fallback step is one registered read of the symbol and border memories.
// rst_n is synchronous; it clears progress and index_mode, the memories keep their data.
// a request is taken only while the search is idle and the result register is free
// or being emptied in the same cycle; a stalled result holds the search result.
module kmp_failure_table_builder #(
  parameter int MAX_LEN     = kftb_pkg::MAX_LEN_DEF,
  parameter int SYMBOL_BITS = kftb_pkg::SYMBOL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  kftb_pkg::in_t                 in_payload,
  output logic                          out_valid,
  input  logic                          out_stall,
  output kftb_pkg::out_t                out_payload,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kftb_pkg::CFG_AW-1:0]   paddr,
  input  logic [kftb_pkg::CFG_DW-1:0]   pwdata,
  output logic [kftb_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import kftb_pkg::*;

  logic    index_mode_r;
  logic    sel_mode;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign pready   = 1'b1;
  assign sel_mode = (paddr[CFG_AW-1:2] == ADDR_INDEX_MODE[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_mode_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && sel_mode) begin
      index_mode_r <= pwdata[0];
    end
  end

  assign prdata = sel_mode ? CFG_DW'(index_mode_r) : '0;

  kftb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  kftb_datapath #(
    .MAX_LEN     (MAX_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_payload  (in_payload),
    .index_mode  (index_mode_r),
    .cmd         (cmd),
    .sts         (sts),
    .out_payload (out_payload)
  );

endmodule

// ===== tb/kmp_failure_table_builder_tb.sv =====
// self-checking testbench for the streaming kmp failure table builder
`timescale 1ns / 1ps

module kmp_failure_table_builder_tb;
  import kftb_pkg::*;

  localparam int                CYCLE_LIMIT   = 400000;
  localparam int                LONG_HOLD     = 200;
  localparam int                DRAIN_TAIL    = 20;
  localparam int                PHASES        = 6;
  localparam int                PHASE_ITEMS   = 185;
  localparam int                STR_CAP       = 256;
  localparam logic [CFG_AW-1:0] ADDR_UNMAPPED = 3'h4;

  typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_e;
  typedef enum int {STR_SAME, STR_SMALL, STR_PERIODIC, STR_NOISE} str_style_e;

  typedef struct packed {
    row_kind_e          kind;
    in_t                req;
    out_t               want;
    logic [CFG_AW-1:0]  addr;
    logic [CFG_DW-1:0]  data;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_t               in_payload;
  logic              out_valid;
  logic              out_stall;
  out_t              out_payload;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // predictor state
  int   sym_mem [0:STR_CAP-1];
  int   border_mem [0:STR_CAP-1];
  int   cur_border;
  int   str_len;
  logic cfg_mode;

  out_t     pending_borders[$];
  dir_row_t dir_rows[$];
  int       err_cnt;
  int       items_sent;
  int       cycle_cnt;
  bit       offering;
  bit       quiet;
  bit       hold_req;

  kmp_failure_table_builder uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // border length (or last border index) of the prefix ending at this symbol
  function automatic out_t next_border(input in_t req);
    int   pos;
    int   j;
    int   sym;
    out_t res;
    sym = int'(req.symbol);
    if (req.first) begin
      str_len = 0;
      cur_border = 0;
    end
    pos = str_len;
    res = '0;
    if (pos >= STR_CAP) begin
      res.overflow = 1'b1;
      res.position = OVF_POSITION;
      return res;
    end
    j = 0;
    if (pos > 0) begin
      j = cur_border;
      if (j >= pos) j = pos - 1;
      while (j > 0 && sym != sym_mem[j]) j = border_mem[j-1];
      if (sym == sym_mem[j]) j++;
    end
    sym_mem[pos] = sym;
    border_mem[pos] = j;
    cur_border = j;
    str_len = pos + 1;
    res.value = VALUE_W'(cfg_mode ? j - 1 : j);
    res.position = POSITION_W'(pos);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  function automatic dir_row_t item_row(input logic [7:0] sym, input logic first);
    dir_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.req.symbol = sym;
    row.req.first = first;
    return row;
  endfunction

  function automatic dir_row_t typed_row(input logic [7:0] sym, input logic first,
                                         input logic signed [VALUE_W-1:0] value,
                                         input logic [POSITION_W-1:0] position);
    dir_row_t row;
    row = item_row(sym, first);
    row.kind = ROW_TYPED;
    row.want.value = value;
    row.want.position = position;
    row.want.overflow = 1'b0;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_AW-1:0] addr,
                                       input logic [CFG_DW-1:0] data);
    dir_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.addr = addr;
    row.data = data;
    return row;
  endfunction

  task automatic send_item(input in_t req, input int gap, input bit typed, input out_t want);
    out_t guess;
    if (gap > 0 && offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    if (gap > 0) repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    in_payload <= req;
    offering = 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    guess = next_border(req);
    pending_borders.push_back(typed ? want : guess);
    items_sent++;
  endtask

  task automatic wait_drained();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      @(posedge clk);
    end
    while (pending_borders.size() != 0) @(posedge clk);
  endtask

  // apb write followed by a read back of index_mode
  task automatic program_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (addr == ADDR_INDEX_MODE) cfg_mode = data[0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_INDEX_MODE;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata !== CFG_DW'(cfg_mode)) begin
      $error("index_mode: expected %0d actual %0d", cfg_mode, prdata);
      err_cnt++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_string(input int len, input str_style_e style, input bit fresh);
    logic [7:0] base;
    logic [7:0] motif [0:7];
    int         per;
    int         alpha;
    in_t        req;
    base = 8'($urandom_range(0, 255));
    per = $urandom_range(1, 8);
    alpha = $urandom_range(1, 3);
    for (int k = 0; k < 8; k++) motif[k] = 8'(int'(base) + $urandom_range(0, alpha));
    for (int i = 0; i < len; i++) begin
      case (style)
        STR_SAME:  req.symbol = base;
        STR_SMALL: req.symbol = 8'(int'(base) + $urandom_range(0, alpha));
        STR_PERIODIC: begin
          // mostly a repeated motif, now and then a mutation to force fallback
          if ($urandom_range(0, 15) == 0) req.symbol = 8'(int'(base) + $urandom_range(0, alpha));
          else req.symbol = motif[i % per];
        end
        default:   req.symbol = 8'($urandom_range(0, 255));
      endcase
      if (i == 0) req.first = fresh;
      else req.first = (style == STR_NOISE) && ($urandom_range(0, 29) == 0);
      send_item(req, pick_gap(), 1'b0, '0);
    end
  endtask

  // receiver side: random stalls plus one long hold-off on request
  initial begin : receiver
    int stall_left;
    int hold_cycles;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cycles = 0;
        out_stall <= 1'b1;
        while (hold_cycles < LONG_HOLD) begin
          @(posedge clk);
          hold_cycles++;
        end
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (quiet || $urandom_range(0, 99) < 70) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_borders.size() == 0) begin
        $error("result with nothing pending: value %0d position %0d overflow %0b",
               out_payload.value, out_payload.position, out_payload.overflow);
        err_cnt++;
      end else begin
        want = pending_borders.pop_front();
        if (out_payload.value !== want.value) begin
          $error("value: expected %0d actual %0d", want.value, out_payload.value);
          err_cnt++;
        end
        if (out_payload.position !== want.position) begin
          $error("position: expected %0d actual %0d", want.position, out_payload.position);
          err_cnt++;
        end
        if (out_payload.overflow !== want.overflow) begin
          $error("overflow: expected %0b actual %0b", want.overflow, out_payload.overflow);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("kmp_failure_table_builder_tb failed");
    $finish;
  end

  initial begin : stimulus
    int               r;
    int               len;
    int               phase_start;
    str_style_e       style;
    logic [CFG_DW-1:0] wdata;
    err_cnt = 0;
    items_sent = 0;
    offering = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    cfg_mode = 1'b0;
    cur_border = 0;
    str_len = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_payload <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;

    // no first flag right after reset, then borders, fallback, both modes
    dir_rows.push_back(typed_row(8'h00, 1'b0, 9'sd0, 8'd0));
    dir_rows.push_back(typed_row(8'h00, 1'b0, 9'sd1, 8'd1));
    dir_rows.push_back(item_row(8'hFF, 1'b0));
    dir_rows.push_back(item_row(8'h00, 1'b0));
    dir_rows.push_back(typed_row(8'hFF, 1'b1, 9'sd0, 8'd0));
    dir_rows.push_back(typed_row(8'hFF, 1'b0, 9'sd1, 8'd1));
    dir_rows.push_back(typed_row(8'hFF, 1'b0, 9'sd2, 8'd2));
    dir_rows.push_back(item_row(8'h5A, 1'b0));
    dir_rows.push_back(item_row(8'hFF, 1'b0));
    dir_rows.push_back(cfg_row(ADDR_INDEX_MODE, 32'h0000_0001));
    dir_rows.push_back(typed_row(8'hA5, 1'b1, -9'sd1, 8'd0));
    dir_rows.push_back(typed_row(8'hA5, 1'b0, 9'sd0, 8'd1));
    dir_rows.push_back(item_row(8'h3C, 1'b0));
    // write beyond the register map must leave index_mode alone
    dir_rows.push_back(cfg_row(ADDR_UNMAPPED, 32'h0000_0000));
    dir_rows.push_back(typed_row(8'h3C, 1'b1, -9'sd1, 8'd0));
    dir_rows.push_back(item_row(8'hC3, 1'b0));
    dir_rows.push_back(item_row(8'h3C, 1'b0));
    dir_rows.push_back(item_row(8'hC3, 1'b0));
    dir_rows.push_back(item_row(8'h3C, 1'b0));
    dir_rows.push_back(item_row(8'h00, 1'b0));
    dir_rows.push_back(cfg_row(ADDR_INDEX_MODE, 32'hFFFF_FFFE));
    dir_rows.push_back(typed_row(8'h80, 1'b1, 9'sd0, 8'd0));
    dir_rows.push_back(item_row(8'h01, 1'b0));
    dir_rows.push_back(item_row(8'h80, 1'b0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_drained();
        program_reg(dir_rows[i].addr, dir_rows[i].data);
      end else begin
        send_item(dir_rows[i].req, pick_gap(), dir_rows[i].kind == ROW_TYPED,
                  dir_rows[i].want);
      end
    end

    // fill to capacity in mode 0: border climbs to 255, then overflow
    send_string(STR_CAP + 3, STR_SAME, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      wdata = $urandom;
      wdata[0] = (ph % 2 == 0);
      program_reg(ADDR_INDEX_MODE, wdata);
      quiet = (ph == 3);
      if (ph == 0) begin
        // long receiver hold-off while the sender keeps offering
        hold_req = 1'b1;
        send_string(STR_CAP + 4, STR_SAME, 1'b1);
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 40) style = STR_PERIODIC;
        else if (r < 65) style = STR_SMALL;
        else if (r < 75) style = STR_SAME;
        else style = STR_NOISE;
        r = $urandom_range(0, 99);
        if (r < 90) len = $urandom_range(1, 40);
        else if (r < 97) len = $urandom_range(41, 200);
        else len = $urandom_range(250, 300);
        send_string(len, style, (style == STR_NOISE) ? 1'($urandom_range(0, 1)) : 1'b1);
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (pending_borders.size() != 0) begin
      $error("%0d results never arrived", pending_borders.size());
      err_cnt++;
    end
    if (err_cnt == 0) $display("kmp_failure_table_builder_tb passed");
    else $display("kmp_failure_table_builder_tb failed");
    $finish;
  end

endmodule
